### rtl/lms_pkg.sv
// Shared types, mode codes and timing constants for the LED mode sequencer.
package lms_pkg;

  typedef logic [4:0] mode_t;

  localparam logic CMD_TICK     = 1'b0;
  localparam logic CMD_SET_MODE = 1'b1;

  localparam mode_t MODE_STARTUP        = 5'd1;
  localparam mode_t MODE_IDLE           = 5'd2;
  localparam mode_t MODE_NOTIFICATION   = 5'd9;
  localparam mode_t MODE_SUCCESS        = 5'd11;
  localparam mode_t MODE_ERROR          = 5'd12;
  localparam mode_t MODE_WIFI_CONNECTED = 5'd14;
  localparam mode_t MODE_MAX            = 5'd16;

  localparam logic [31:0] STARTUP_TIMEOUT_MS      = 32'd3000;
  localparam logic [31:0] NOTIFICATION_TIMEOUT_MS = 32'd650;
  localparam logic [31:0] SUCCESS_TIMEOUT_MS      = 32'd1200;
  localparam logic [31:0] ERROR_TIMEOUT_MS        = 32'd1800;
  localparam logic [31:0] WIFI_TIMEOUT_MS         = 32'd900;

  localparam logic [7:0] FULL_AMOUNT = 8'd255;

  // One frame after timeout handling, before the ramp is worked out.
  typedef struct packed {
    mode_t       mode;
    logic [31:0] elapsed;
    logic        fading;
    logic        ramp_done;
  } frame_t;

  function automatic logic is_momentary(input mode_t m);
    return (m == MODE_NOTIFICATION) || (m == MODE_SUCCESS) ||
           (m == MODE_ERROR) || (m == MODE_WIFI_CONNECTED);
  endfunction

endpackage

### rtl/lms_fade_ramp.sv
// Cross-fade weight of one frame: elapsed * 255 / FADE_MS by reciprocal multiply.
module lms_fade_ramp #(
  parameter int unsigned FADE_MS = 220
) (
  input  lms_pkg::frame_t frame,
  output logic [7:0]      fade_amount,
  output logic            fade_applied
);
  import lms_pkg::*;

  // elapsed stays below FADE_MS whenever the ramp is still running
  localparam int ELW   = $clog2(FADE_MS + 1);
  localparam int NW    = ELW + 8;
  localparam int SHIFT = NW + $clog2(FADE_MS);
  localparam int RW    = SHIFT + 1;
  localparam int PW    = NW + RW;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << SHIFT) + 64'(FADE_MS) - 64'd1) / 64'(FADE_MS));

  logic [ELW-1:0] ramp_ms;
  logic [NW-1:0]  numer;
  logic [PW-1:0]  product;

  always_comb begin
    ramp_ms = frame.elapsed[ELW-1:0];
    numer   = {ramp_ms, 8'd0} - NW'(ramp_ms);
    product = PW'(numer) * PW'(RECIP);
    fade_applied = frame.fading;
    if (!frame.fading || frame.ramp_done) begin
      fade_amount = FULL_AMOUNT;
    end else begin
      fade_amount = product[SHIFT +: 8];
    end
  end

endmodule

### rtl/led_mode_sequencer_core.sv
// Top level of the LED ring mode sequencer: mode timeouts, frame pacing, fade ramp.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_ready   command, mode_request, now_ms
//   out      source     out_valid/out_ready active_mode, elapsed_in_mode,
//                                           fade_amount, fade_applied
//
// One request is taken every cycle unless a stall on out holds it back. A
// request lands in the input register, then updates the mode state and fills
// the frame register, and the ramp multiplier then fills the result register.
// Set-mode requests and ticks that come too soon after the last frame update
// state (or not) and make no result. A stall on out back-pressures each stage
// in turn; in_ready stays high while any stage ahead has room. Reset clears
// the control and restores the startup mode state.
module led_mode_sequencer_core #(
  parameter int unsigned FRAME_INTERVAL_MS = 20,
  parameter int unsigned FADE_MS           = 220
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [4:0]  mode_request,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  active_mode,
  output logic [31:0] elapsed_in_mode,
  output logic [7:0]  fade_amount,
  output logic        fade_applied
);
  import lms_pkg::*;

  // Input register
  logic        s1_valid;
  logic        s1_command;
  mode_t       s1_mode_request;
  logic [31:0] s1_now;

  // Frame register
  logic        s2_valid;
  frame_t      s2_frame;

  // Mode state
  mode_t       current_mode;
  mode_t       remembered_mode;
  logic [31:0] mode_start_time;
  logic [31:0] last_frame_time;
  logic        fading;
  logic        frame_seen;

  // Handshake between stages
  logic out_advance;
  logic s2_load;
  logic s1_fire;

  // Work of the state stage
  logic [31:0] elapsed_raw;
  logic [31:0] since_frame;
  logic        throttled;
  mode_t       return_mode;
  mode_t       timeout_mode;
  logic        timeout;
  frame_t      frame;
  logic        set_ok;
  mode_t       remembered_next;
  logic        frame_made;

  logic [7:0]  ramp_amount;
  logic        ramp_applied;

  assign out_advance = !out_valid || out_ready;
  assign s2_load     = !s2_valid || out_advance;
  assign s1_fire     = s1_valid && s2_load;
  assign in_ready    = !s1_valid || s2_load;

  always_comb begin
    elapsed_raw = s1_now - mode_start_time;
    since_frame = s1_now - last_frame_time;
    throttled   = frame_seen && (since_frame < 32'(FRAME_INTERVAL_MS));

    // Momentary modes but wifi fall back to the remembered one, never a momentary.
    return_mode  = is_momentary(remembered_mode) ? MODE_IDLE : remembered_mode;
    timeout      = 1'b0;
    timeout_mode = MODE_IDLE;
    case (current_mode)
      MODE_STARTUP: begin
        timeout = elapsed_raw >= STARTUP_TIMEOUT_MS;
      end
      MODE_NOTIFICATION: begin
        timeout      = elapsed_raw >= NOTIFICATION_TIMEOUT_MS;
        timeout_mode = return_mode;
      end
      MODE_SUCCESS: begin
        timeout      = elapsed_raw >= SUCCESS_TIMEOUT_MS;
        timeout_mode = return_mode;
      end
      MODE_ERROR: begin
        timeout      = elapsed_raw >= ERROR_TIMEOUT_MS;
        timeout_mode = return_mode;
      end
      MODE_WIFI_CONNECTED: begin
        timeout = elapsed_raw >= WIFI_TIMEOUT_MS;
      end
      default: begin
        timeout = 1'b0;
      end
    endcase

    // A timeout restarts the mode now, so the frame sees zero elapsed time.
    frame.mode      = timeout ? timeout_mode : current_mode;
    frame.elapsed   = timeout ? 32'd0 : elapsed_raw;
    frame.fading    = timeout || fading;
    frame.ramp_done = frame.elapsed >= 32'(FADE_MS);

    // Ignore out-of-range codes and requests for the mode already running.
    set_ok = (s1_mode_request <= MODE_MAX) && (s1_mode_request != current_mode);
    remembered_next = remembered_mode;
    if (is_momentary(s1_mode_request)) begin
      remembered_next = is_momentary(current_mode) ? MODE_IDLE : current_mode;
    end else if (!is_momentary(current_mode)) begin
      remembered_next = current_mode;
    end

    frame_made = s1_fire && (s1_command == CMD_TICK) && !throttled;
  end

  lms_fade_ramp #(
    .FADE_MS(FADE_MS)
  ) u_fade_ramp (
    .frame       (s2_frame),
    .fade_amount (ramp_amount),
    .fade_applied(ramp_applied)
  );

  // Control and mode state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      out_valid       <= 1'b0;
      current_mode    <= MODE_STARTUP;
      remembered_mode <= MODE_IDLE;
      mode_start_time <= 32'd0;
      last_frame_time <= 32'd0;
      fading          <= 1'b1;
      frame_seen      <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_load) begin
        s2_valid <= frame_made;
      end
      if (out_advance) begin
        out_valid <= s2_valid;
      end

      if (s1_fire) begin
        if (s1_command == CMD_SET_MODE) begin
          if (set_ok) begin
            current_mode    <= s1_mode_request;
            remembered_mode <= remembered_next;
            mode_start_time <= s1_now;
            fading          <= 1'b1;
          end
        end else if (!throttled) begin
          frame_seen      <= 1'b1;
          last_frame_time <= s1_now;
          current_mode    <= frame.mode;
          if (timeout) begin
            mode_start_time <= s1_now;
          end
          // Drop the fade once the ramp reaches full weight.
          fading <= frame.fading && !frame.ramp_done;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_command      <= command;
      s1_mode_request <= mode_request;
      s1_now          <= now_ms;
    end
    if (s2_load) begin
      s2_frame <= frame;
    end
    if (out_advance) begin
      active_mode     <= s2_frame.mode;
      elapsed_in_mode <= s2_frame.elapsed;
      fade_amount     <= ramp_amount;
      fade_applied    <= ramp_applied;
    end
  end

endmodule

### rtl/lms_checker.sv
// Port-level assertions for the LED mode sequencer and their bind.
module lms_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  active_mode,
  input logic [31:0] elapsed_in_mode,
  input logic [7:0]  fade_amount,
  input logic        fade_applied
);
  import lms_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_mode_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (active_mode <= MODE_MAX))
    else $error("result mode code out of range");

  a_no_fade_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !fade_applied) |-> (fade_amount == FULL_AMOUNT))
    else $error("unfaded frame without full weight");

  a_fade_start_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fade_applied && (elapsed_in_mode == 32'd0)) |-> (fade_amount == 8'd0))
    else $error("fade weight not zero at mode start");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(active_mode) &&
                                   $stable(elapsed_in_mode) && $stable(fade_amount)))
    else $error("stalled result changed");

endmodule

bind led_mode_sequencer_core lms_checker u_lms_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .active_mode    (active_mode),
  .elapsed_in_mode(elapsed_in_mode),
  .fade_amount    (fade_amount),
  .fade_applied   (fade_applied)
);

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench for led_mode_sequencer_core: directed table and predictor-checked random requests.
module tb;
  import lms_pkg::*;

  // Block configuration under test; the predictor uses the same values.
  localparam int unsigned FRAME_MS = 20;
  localparam int unsigned RAMP_MS  = 220;

  localparam int RANDOM_TARGET = 375;  // random requests sent after the directed table
  localparam int MAX_GAP       = 18;   // longest idle stretch on either side, in cycles
  localparam int STALL_LIMIT   = 1000; // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES  = 10;   // input, frame and result registers; leave margin
  localparam int REPORT_LIMIT  = 10;

  // Mode codes the package leaves unnamed, plus the two ends of the illegal range.
  localparam mode_t MODE_OFF         = 5'd0;
  localparam mode_t MODE_MUSIC       = 5'd6;
  localparam mode_t MODE_LOW_BATTERY = 5'd16;
  localparam mode_t MODE_FIRST_BAD   = 5'd17;
  localparam mode_t MODE_LAST_BAD    = 5'd31;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] elapsed;
    logic [7:0]  amount;
    logic        applied;
  } frame_result_t;

  // How a directed row is checked: no frame at all, a frame typed in the row,
  // or whatever the predictor works out.
  typedef enum logic [1:0] {ROW_SILENT, ROW_FRAME, ROW_PREDICT} row_kind_t;

  typedef struct packed {
    logic          cmd;
    mode_t         req;
    logic [31:0]   now;
    row_kind_t     kind;
    frame_result_t frame;
  } stim_row_t;

  localparam frame_result_t NO_FRAME = '0;
  localparam int NUM_DIRECTED = 25;

  // Directed walk: fade start and end after reset, frame throttling, the
  // startup timeout, ignored requests (same mode, codes above the last mode),
  // every momentary timeout, momentary-to-momentary chaining, and a time
  // stamp wrap that both passes and trips the frame throttle.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{CMD_TICK,     MODE_OFF,            32'd0,    ROW_FRAME,
      '{MODE_STARTUP, 32'd0, 8'd0, 1'b1}},
    '{CMD_TICK,     MODE_OFF,            32'd10,   ROW_SILENT,  NO_FRAME},
    '{CMD_TICK,     MODE_OFF,            32'd220,  ROW_FRAME,
      '{MODE_STARTUP, 32'd220, FULL_AMOUNT, 1'b1}},
    '{CMD_TICK,     MODE_OFF,            32'd240,  ROW_FRAME,
      '{MODE_STARTUP, 32'd240, FULL_AMOUNT, 1'b0}},
    '{CMD_SET_MODE, MODE_STARTUP,        32'd250,  ROW_SILENT,  NO_FRAME},
    '{CMD_SET_MODE, MODE_FIRST_BAD,      32'd260,  ROW_SILENT,  NO_FRAME},
    '{CMD_SET_MODE, MODE_LAST_BAD,       32'd270,  ROW_SILENT,  NO_FRAME},
    '{CMD_TICK,     MODE_LAST_BAD,       32'd3000, ROW_FRAME,
      '{MODE_IDLE, 32'd0, 8'd0, 1'b1}},
    '{CMD_SET_MODE, MODE_NOTIFICATION,   32'd3010, ROW_SILENT,  NO_FRAME},
    '{CMD_TICK,     MODE_OFF,            32'd3020, ROW_PREDICT, NO_FRAME},
    '{CMD_TICK,     MODE_OFF,            32'd3660, ROW_PREDICT, NO_FRAME},
    '{CMD_SET_MODE, MODE_MUSIC,          32'd3700, ROW_SILENT,  NO_FRAME},
    '{CMD_SET_MODE, MODE_SUCCESS,        32'd3710, ROW_SILENT,  NO_FRAME},
    '{CMD_TICK,     MODE_OFF,            32'd4910, ROW_PREDICT, NO_FRAME},
    '{CMD_SET_MODE, MODE_ERROR,          32'd4920, ROW_SILENT,  NO_FRAME},
    '{CMD_SET_MODE, MODE_WIFI_CONNECTED, 32'd4930, ROW_SILENT,  NO_FRAME},
    '{CMD_TICK,     MODE_OFF,            32'd5830, ROW_PREDICT, NO_FRAME},
    '{CMD_SET_MODE, MODE_ERROR,          32'd5840, ROW_SILENT,  NO_FRAME},
    '{CMD_TICK,     MODE_OFF,            32'd7640, ROW_PREDICT, NO_FRAME},
    '{CMD_SET_MODE, MODE_OFF,            32'd7650, ROW_SILENT,  NO_FRAME},
    '{CMD_SET_MODE, MODE_LOW_BATTERY,    32'd7660, ROW_SILENT,  NO_FRAME},
    '{CMD_TICK,     MODE_OFF,      32'hFFFF_FFFF,  ROW_PREDICT, NO_FRAME},
    '{CMD_TICK,     MODE_OFF,            32'd5,    ROW_SILENT,  NO_FRAME},
    '{CMD_SET_MODE, MODE_STARTUP,        32'd10,   ROW_SILENT,  NO_FRAME},
    '{CMD_TICK,     MODE_OFF,            32'd19,   ROW_PREDICT, NO_FRAME}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = CMD_TICK;
  logic [4:0]  mode_request = '0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  active_mode;
  logic [31:0] elapsed_in_mode;
  logic [7:0]  fade_amount;
  logic        fade_applied;

  led_mode_sequencer_core #(
    .FRAME_INTERVAL_MS(FRAME_MS),
    .FADE_MS(RAMP_MS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .mode_request(mode_request),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .active_mode(active_mode),
    .elapsed_in_mode(elapsed_in_mode),
    .fade_amount(fade_amount),
    .fade_applied(fade_applied)
  );

  always #5 clk = ~clk;

  // Sequencer state as the predictor sees it.
  mode_t       seq_mode;
  mode_t       saved_mode;
  logic [31:0] mode_start;
  logic [31:0] last_frame;
  bit          ramp_active;
  bit          frame_seen;

  frame_result_t expected_frames[$];

  int  failures;
  int  frames_checked;
  int  requests_sent;
  int  random_effective;
  int  idle_cycles;
  bit  in_steady;
  bit  out_steady;

  function automatic bit is_transient(mode_t m);
    return m inside {MODE_NOTIFICATION, MODE_SUCCESS, MODE_ERROR, MODE_WIFI_CONNECTED};
  endfunction

  // Apply one request to the predicted state. took_effect is set when the
  // request changes the mode or makes a frame; made_frame when a frame comes out.
  task automatic step_sequencer(input logic cmd, input mode_t req, input logic [31:0] now,
                                output bit took_effect, output bit made_frame,
                                output frame_result_t frame);
    logic [31:0]     since;
    logic [31:0]     age;
    mode_t           next_mode;
    bit              timed_out;
    longint unsigned scaled;
    took_effect = 1'b0;
    made_frame  = 1'b0;
    frame       = NO_FRAME;
    timed_out   = 1'b0;
    next_mode   = seq_mode;

    if (cmd == CMD_SET_MODE) begin
      // Drop repeats and codes past the last mode.
      if (req > MODE_MAX || req == seq_mode) return;
      // Remember the mode to fall back to; a momentary mode never gets remembered.
      if (is_transient(req))
        saved_mode = is_transient(seq_mode) ? MODE_IDLE : seq_mode;
      else if (!is_transient(seq_mode))
        saved_mode = seq_mode;
      seq_mode    = req;
      mode_start  = now;
      ramp_active = 1'b1;
      took_effect = 1'b1;
      return;
    end

    // Drop ticks that come before the frame interval is up (wrapping compare).
    since = now - last_frame;
    if (frame_seen && since < FRAME_MS) return;
    frame_seen = 1'b1;
    last_frame = now;

    age = now - mode_start;
    case (seq_mode)
      MODE_STARTUP: begin
        timed_out = age >= STARTUP_TIMEOUT_MS;
        next_mode = MODE_IDLE;
      end
      MODE_NOTIFICATION: begin
        timed_out = age >= NOTIFICATION_TIMEOUT_MS;
        next_mode = is_transient(saved_mode) ? MODE_IDLE : saved_mode;
      end
      MODE_SUCCESS: begin
        timed_out = age >= SUCCESS_TIMEOUT_MS;
        next_mode = is_transient(saved_mode) ? MODE_IDLE : saved_mode;
      end
      MODE_ERROR: begin
        timed_out = age >= ERROR_TIMEOUT_MS;
        next_mode = is_transient(saved_mode) ? MODE_IDLE : saved_mode;
      end
      MODE_WIFI_CONNECTED: begin
        timed_out = age >= WIFI_TIMEOUT_MS;
        next_mode = MODE_IDLE;
      end
      default: timed_out = 1'b0;
    endcase
    // A timeout restarts the clock and the fade but leaves the remembered mode.
    if (timed_out) begin
      seq_mode    = next_mode;
      mode_start  = now;
      ramp_active = 1'b1;
    end

    age           = now - mode_start;
    frame.mode    = seq_mode;
    frame.elapsed = age;
    if (ramp_active) begin
      frame.applied = 1'b1;
      if (age == 0) begin
        frame.amount = 8'd0;
      end else if (age >= RAMP_MS) begin
        frame.amount = FULL_AMOUNT;
      end else begin
        scaled       = (longint'(age) * 255) / RAMP_MS;
        frame.amount = scaled[7:0];
      end
      // Clear the fade once it has reached full weight.
      if (frame.amount == FULL_AMOUNT) ramp_active = 1'b0;
    end else begin
      frame.amount  = FULL_AMOUNT;
      frame.applied = 1'b0;
    end
    took_effect = 1'b1;
    made_frame  = 1'b1;
  endtask

  task automatic report_failure(input string what);
    failures++;
    if (failures <= REPORT_LIMIT) $display("[%0t] %s", $realtime, what);
  endtask

  // Present one request and hold it until the block takes it. Enter and leave
  // at a rising edge; the request is predicted at the edge that accepts it.
  task automatic send_request(input logic cmd, input mode_t req, input logic [31:0] now,
                              output bit took_effect, output bit made_frame,
                              output frame_result_t frame);
    int gap;
    if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    // Lower valid only when a gap follows, so valid never drops and rises in one step.
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    mode_request <= req;
    now_ms       <= now;
    do @(posedge clk); while (!(in_valid && in_ready));
    requests_sent++;
    step_sequencer(cmd, req, now, took_effect, made_frame, frame);
  endtask

  // Result side: stall for a random number of cycles, then take one result.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Compare every accepted frame with the oldest expectation.
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      frames_checked++;
      if (expected_frames.size() == 0) begin
        report_failure($sformatf(
          "unexpected frame: mode %0d elapsed %0d amount %0d applied %0d",
          active_mode, elapsed_in_mode, fade_amount, fade_applied));
      end else begin
        want = expected_frames.pop_front();
        if (active_mode !== want.mode || elapsed_in_mode !== want.elapsed ||
            fade_amount !== want.amount || fade_applied !== want.applied)
          report_failure($sformatf(
            {"frame mismatch: expected mode %0d elapsed %0d amount %0d applied %0d,",
             " got %0d %0d %0d %0d"},
            want.mode, want.elapsed, want.amount, want.applied,
            active_mode, elapsed_in_mode, fade_amount, fade_applied));
      end
    end
  end

  // Give up when neither side has handshaken for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit            took_effect;
    bit            made_frame;
    frame_result_t frame;
    logic          cmd;
    mode_t         req;
    logic [31:0]   now;
    logic [31:0]   clock_ms;
    int            roll;

    // Restore the predicted power-up state while reset is held.
    seq_mode    = MODE_STARTUP;
    saved_mode  = MODE_IDLE;
    mode_start  = '0;
    last_frame  = '0;
    ramp_active = 1'b1;
    frame_seen  = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: typed expectations where obvious, predictor elsewhere.
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].cmd, directed_rows[i].req, directed_rows[i].now,
                   took_effect, made_frame, frame);
      case (directed_rows[i].kind)
        ROW_FRAME:   expected_frames.push_back(directed_rows[i].frame);
        ROW_PREDICT: if (made_frame) expected_frames.push_back(frame);
        default:     ;
      endcase
    end

    // Random part: mostly time running forward with mode changes in between;
    // a few requests carry fully random fields, and time jumps now and then.
    clock_ms = $urandom;
    while (requests_sent < NUM_DIRECTED + RANDOM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        cmd = 1'($urandom_range(0, 1));
        req = mode_t'($urandom_range(0, 31));
        now = $urandom;
      end else if (roll < 25) begin
        cmd      = CMD_SET_MODE;
        req      = (roll < 8) ? mode_t'($urandom_range(MODE_FIRST_BAD, MODE_LAST_BAD))
                              : mode_t'($urandom_range(MODE_OFF, MODE_MAX));
        clock_ms = clock_ms + $urandom_range(0, 30);
        now      = clock_ms;
      end else begin
        cmd = CMD_TICK;
        req = mode_t'($urandom_range(0, 31));
        if (roll < 75)      clock_ms = clock_ms + $urandom_range(0, 60);
        else if (roll < 90) clock_ms = clock_ms + $urandom_range(100, 1000);
        else if (roll < 99) clock_ms = clock_ms + $urandom_range(1000, 3500);
        else                clock_ms = $urandom;
        now = clock_ms;
      end
      send_request(cmd, req, now, took_effect, made_frame, frame);
      if (made_frame) expected_frames.push_back(frame);
      if (took_effect) random_effective++;
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every expected frame, then watch a little longer for strays.
    wait (expected_frames.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d directed rows, %0d random that changed state).",
             requests_sent, NUM_DIRECTED, random_effective);
    $display("Checked %0d frames, %0d failures.", frames_checked, failures);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
